// ===== design/swd_pkg.sv =====
// shared types, constants and step tables for the wave-drive stepper controller
package swd_pkg;

   localparam int unsigned DataWidth  = 16;
   localparam int unsigned CoilCount  = 4;
   localparam int unsigned PhaseWidth = 3;
   localparam int unsigned ActWidth   = 3;
   localparam int unsigned CsrIdxWidth = 2;

   typedef logic signed [DataWidth-1:0] sword_type;
   typedef logic        [DataWidth-1:0] uword_type;
   typedef logic        [CoilCount-1:0] coil_type;
   typedef logic        [PhaseWidth-1:0] phase_type;
   typedef logic        [ActWidth-1:0]  action_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MAX_POSITION  = 2'd0,
      CSR_MIN_POSITION  = 2'd1,
      CSR_STEP_INTERVAL = 2'd2
   } csr_index_type;

   localparam sword_type  MaxPositionReset  = 16'sd1000;
   localparam sword_type  MinPositionReset  = 16'sd0;
   localparam uword_type  StepIntervalReset = 16'd10;
   localparam action_type ActionReset       = 3'd6;
   localparam phase_type  PhaseReset        = 3'd4;
   localparam phase_type  PhaseBetween      = 3'd0;

   // forward order 1-3-2-4: next coil after the coil the rotor sits at
   function automatic phase_type fwd_next(input phase_type ph);
      phase_type nx;
      unique case (ph)
         3'd1:    nx = 3'd3;
         3'd2:    nx = 3'd4;
         3'd3:    nx = 3'd2;
         3'd4:    nx = 3'd1;
         default: nx = PhaseBetween;
      endcase
      return nx;
   endfunction

   // reverse order 1-4-2-3
   function automatic phase_type rev_next(input phase_type ph);
      phase_type nx;
      unique case (ph)
         3'd1:    nx = 3'd4;
         3'd2:    nx = 3'd3;
         3'd3:    nx = 3'd1;
         3'd4:    nx = 3'd2;
         default: nx = PhaseBetween;
      endcase
      return nx;
   endfunction

endpackage

// ===== design/stepper_wave_drive_with_limits_top.sv =====
// wave-drive stepper controller with position limits, one item per clock while req_stall is low
// an accepted item's result is registered and appears in the output register in the cycle after it is accepted
// throughput: one item per clock while req_stall is low; the state update is one short combinational pass
// the output register can be reloaded in the cycle it is taken; a stall holds it and stalls the input
// reset: limits 0..1000, interval 10, standby at phase 4, position 0, coils released
module stepper_wave_drive_with_limits_top
   import swd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic signed [15:0]     req_step_request,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_coils,
   output logic signed [15:0]     rsp_position,
   output logic signed [15:0]     rsp_steps_left,
   output logic                   rsp_moving,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   sword_type  max_position_ff, min_position_ff;
   uword_type  step_interval_ff;

   logic       in_rotate_ff, in_rotate_in;
   action_type coil_action_ff, coil_action_in;
   phase_type  phase_ff, phase_in;
   sword_type  pending_ff, pending_in;
   sword_type  position_ff, position_in;
   uword_type  wait_ff, wait_in;
   coil_type   coil_drive_ff, coil_drive_in;

   logic       rsp_valid_ff, rsp_valid_in;
   coil_type   rsp_coils_ff;
   sword_type  rsp_position_ff, rsp_steps_left_ff;
   logic       rsp_moving_ff, moving_in;

   logic       accept;
   uword_type  wait_dec;
   logic [1:0] coil_sel;
   phase_type  nx;
   logic       fwd_ok, rev_ok;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_position_ff  <= MaxPositionReset;
         min_position_ff  <= MinPositionReset;
         step_interval_ff <= StepIntervalReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_POSITION:  max_position_ff  <= csr_data;
            CSR_MIN_POSITION:  min_position_ff  <= csr_data;
            CSR_STEP_INTERVAL: step_interval_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_rotate_in   = in_rotate_ff;
      coil_action_in = coil_action_ff;
      phase_in       = phase_ff;
      pending_in     = pending_ff;
      position_in    = position_ff;
      wait_in        = wait_ff;
      coil_drive_in  = coil_drive_ff;
      wait_dec       = (wait_ff != '0) ? wait_ff - 16'd1 : wait_ff;
      coil_sel       = coil_action_ff[2:1];
      nx             = PhaseBetween;
      fwd_ok         = (pending_ff > 16'sd0) && (position_ff < max_position_ff);
      rev_ok         = (pending_ff < 16'sd0) && (position_ff > min_position_ff);

      if (req_mode) begin
         pending_in = req_step_request;
      end else begin
         wait_in = wait_dec;
         if (in_rotate_ff) begin
            if (!coil_action_ff[0]) begin
               coil_drive_in     = coil_drive_ff | (coil_type'(1) << coil_sel);
               phase_in          = PhaseBetween;
               coil_action_in[0] = 1'b1;
            end else begin
               coil_drive_in = coil_drive_ff & ~(coil_type'(1) << coil_sel);
               phase_in      = {1'b0, coil_sel} + 3'd1;
            end
            wait_in      = step_interval_ff;
            in_rotate_in = 1'b0;
         end else if (wait_dec == '0) begin
            priority if (fwd_ok || rev_ok) begin
               nx = fwd_ok ? fwd_next(phase_ff) : rev_next(phase_ff);
               // phase between coils: only switch the lit coil off first
               if (nx != PhaseBetween) begin
                  position_in    = fwd_ok ? position_ff + 16'sd1 : position_ff - 16'sd1;
                  pending_in     = fwd_ok ? pending_ff - 16'sd1 : pending_ff + 16'sd1;
                  coil_action_in = {nx[1:0] - 2'd1, 1'b0};
               end
               in_rotate_in = 1'b1;
            end else begin
               coil_drive_in = '0;
               if ((pending_ff > 16'sd0 && position_ff == max_position_ff) ||
                   (pending_ff < 16'sd0 && position_ff == min_position_ff)) begin
                  pending_in = '0;
               end
            end
         end
      end

      moving_in = (pending_in > 16'sd0 && position_in < max_position_ff) ||
                  (pending_in < 16'sd0 && position_in > min_position_ff);
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rotate_ff   <= 1'b0;
         coil_action_ff <= ActionReset;
         phase_ff       <= PhaseReset;
         pending_ff     <= '0;
         position_ff    <= MinPositionReset;
         wait_ff        <= '0;
         coil_drive_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_rotate_ff   <= in_rotate_in;
            coil_action_ff <= coil_action_in;
            phase_ff       <= phase_in;
            pending_ff     <= pending_in;
            position_ff    <= position_in;
            wait_ff        <= wait_in;
            coil_drive_ff  <= coil_drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_coils_ff      <= coil_drive_in;
         rsp_position_ff   <= position_in;
         rsp_steps_left_ff <= pending_in;
         rsp_moving_ff     <= moving_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coils      = rsp_coils_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_steps_left = rsp_steps_left_ff;
   assign rsp_moving     = rsp_moving_ff;

   // wave drive never lights two coils
   a_one_coil: assert property (@(posedge clock) disable iff (reset)
      $onehot0(coil_drive_ff))
      else $error("more than one coil driven");

   // a lit coil means the rotor sits between phases
   a_lit_between: assert property (@(posedge clock) disable iff (reset)
      (coil_drive_ff != '0) |-> (phase_ff == PhaseBetween))
      else $error("coil lit outside between-phase state");

   // a coil action is only armed once the wait has run out
   a_rotate_no_wait: assert property (@(posedge clock) disable iff (reset)
      in_rotate_ff |-> (wait_ff == '0))
      else $error("coil action armed during wait");

   // a tick in the rotate state reloads the interval and returns to standby
   a_rotate_reload: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_mode && in_rotate_ff) |=>
         (!in_rotate_ff && wait_ff == $past(step_interval_ff)))
      else $error("rotate tick did not reload interval");

endmodule
